### hw/rtl/mavf_pkg.sv
package mavf_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_BITS  = 16;
  localparam int RESET_WINDOW = 8;

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int WIN_W = IDX_W + 1;
  localparam int SUM_W = SAMPLE_BITS + IDX_W;
  localparam int CNT_W = $clog2(SUM_W);

  // Controller to datapath
  typedef struct packed {
    logic take;     // latch sample, read the slot being replaced
    logic update;   // fold into sum, write slot, load divider
    logic step;     // one restoring-division step
    logic publish;  // load the output register
  } mavf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;  // current step is the final one
    logic out_free;  // output register can take a result this cycle
  } mavf_sts_t;

  // Zero reads as one, anything above the ring depth as the ring depth.
  function automatic logic [WIN_W-1:0] win_clamp(input logic [WIN_W-1:0] v);
    logic [WIN_W-1:0] r;
    if (v == '0) begin
      r = WIN_W'(1);
    end else if (v > WIN_W'(MAX_WINDOW)) begin
      r = WIN_W'(MAX_WINDOW);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### hw/rtl/mavf_if.sv
interface mavf_in_if import mavf_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mavf_out_if import mavf_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface

### hw/rtl/mavf_ctrl.sv
module mavf_ctrl import mavf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mavf_sts_t sts,
  output mavf_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.take     = 1'b1;
          state_nxt    = ST_LOAD;
          in_ready_nxt = 1'b0;
        end
      end
      ST_LOAD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.publish  = 1'b1;
          state_nxt    = ST_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt    = ST_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

  a_take_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> cmd.update)
    else $error("accepted item not folded into the sum next cycle");

  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.div_last) |=> (state_r == ST_DONE && !in_ready_r))
    else $error("division finished but controller did not move to publish");

endmodule

### hw/rtl/mavf_datapath.sv
module mavf_datapath import mavf_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [WIN_W-1:0]              cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  mavf_cmd_t                     cmd,
  output mavf_sts_t                     sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_average
);

  // Window ring and per-slot valid bits (an unwritten slot reads as zero)
  logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]         slot_vld_r;

  logic [WIN_W-1:0]              win_r;
  logic [IDX_W-1:0]              idx_r;
  logic signed [SUM_W-1:0]       sum_r;

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] rdata_r;
  logic                          old_vld_r;

  // Restoring divider: quo_r shifts dividend out and quotient in
  logic [SUM_W-1:0]              quo_r;
  logic [IDX_W-1:0]              rem_r;
  logic                          neg_r;
  logic [CNT_W-1:0]              cnt_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] avg_r;

  logic signed [SAMPLE_BITS-1:0] old_val;
  logic signed [SUM_W-1:0]       sum_nxt;
  logic [WIN_W-1:0]              idx_inc;
  logic [IDX_W-1:0]              idx_nxt;
  logic [WIN_W-1:0]              rem_sh;
  logic                          q_bit;
  logic [IDX_W-1:0]              rem_nxt;
  logic [SAMPLE_BITS-1:0]        quo_low;

  assign old_val = old_vld_r ? rdata_r : '0;
  assign sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(sample_r);
  assign idx_inc = WIN_W'(idx_r) + WIN_W'(1);
  assign idx_nxt = (idx_inc >= win_r) ? '0 : idx_inc[IDX_W-1:0];

  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign q_bit   = (rem_sh >= win_r);
  assign rem_nxt = q_bit ? IDX_W'(rem_sh - win_r) : rem_sh[IDX_W-1:0];
  assign quo_low = quo_r[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rdata_r <= mem[idx_r];
    end
    if (cmd.update) begin
      mem[idx_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= win_clamp(WIN_W'(RESET_WINDOW));
      idx_r      <= '0;
      sum_r      <= '0;
      slot_vld_r <= '0;
    end else if (cfg_we) begin
      win_r      <= win_clamp(cfg_wdata);
      idx_r      <= '0;
      sum_r      <= '0;
      slot_vld_r <= '0;
    end else if (cmd.update) begin
      sum_r             <= sum_nxt;
      idx_r             <= idx_nxt;
      slot_vld_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sample_r  <= in_sample;
      old_vld_r <= slot_vld_r[idx_r];
    end
    if (cmd.update) begin
      neg_r <= sum_nxt[SUM_W-1];
      quo_r <= sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.step) begin
      quo_r <= {quo_r[SUM_W-2:0], q_bit};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.publish) begin
      avg_r <= neg_r ? -quo_low : quo_low;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.div_last = (cnt_r == CNT_W'(SUM_W - 1));
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_average  = avg_r;

  a_idx_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (WIN_W'(idx_r) < win_r) && (win_r != '0))
    else $error("write index outside the configured window");

  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || out_ready))
    else $error("result overwrote one not yet taken");

endmodule

### hw/rtl/moving_average_filter_top.sv
// Simple moving average filter.
//
// in_ch  : one signed sample per item (valid/ready). The sample replaces the
//          oldest of window_size slots in a ring and a running sum is kept.
// out_ch : one signed average per input item, the window sum divided by
//          window_size and truncated toward zero. Empty slots count as zero.
// cfg_we / cfg_wdata : write window_size (0 reads as 1, above 64 as 64);
//          the write clears the ring, write index and sum. Write only idle.
//
// From input accept to output valid: the accept edge reads the replaced
// slot, the next cycle updates the sum, 22 steps of a one-bit-per-cycle
// restoring divider (22-bit sum by window_size) follow, then the output
// register is loaded once it is free. Ready drops at the accept and returns
// with the output load, so a new item is taken only after the last is done.
// A new item is accepted while the previous result still waits in the
// output register; if the receiver stalls, the finished next result holds
// in the divider until the output register drains.
// Reset (rst_n low, synchronous): window_size 8, ring empty, sum zero,
// no result pending, ready high.
module moving_average_filter_top import mavf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  mavf_in_if.sink          in_ch,
  mavf_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_wdata
);

  mavf_cmd_t cmd;
  mavf_sts_t sts;
  logic      in_ready;
  logic      out_valid;
  logic signed [SAMPLE_BITS-1:0] out_average;

  // Sequence one item: take, fold into sum, divide, publish
  mavf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Ring, running sum, divider and output register
  mavf_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_sample   (in_ch.sample),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ch.ready),
    .out_valid   (out_valid),
    .out_average (out_average)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.average = out_average;

endmodule
